[sv/qvr_pkg.sv]
// Shared widths, stage counts and the divider stage record for the
// quaternion vector rotation pipeline. No dependencies.
`default_nettype none
package qvr_pkg;
	localparam int DATA_W    = 16;              // field width, Q4.12
	localparam int SQ_W      = 2 * DATA_W;      // one quaternion part product
	localparam int MAT_W     = SQ_W + 2;        // rotation matrix entry
	localparam int NORM_W    = SQ_W + 1;        // squared norm, unsigned
	localparam int PROD_W    = MAT_W + DATA_W;  // matrix entry times vector part
	localparam int SUM_W     = PROD_W + 2;      // one row of R * v
	localparam int NUM_W     = SUM_W + 1;       // 2|r| + n
	localparam int DEN_W     = NORM_W + 1;      // 2n
	localparam int QUO_W     = DATA_W + 1;      // quotient, enough to detect clamping
	localparam int IDX_W     = $clog2(QUO_W);
	localparam int FRONT_STG = 5;
	localparam int NSTG      = FRONT_STG + QUO_W + 1;

	localparam logic [QUO_W-1:0] POS_LIM = QUO_W'((1 << (DATA_W - 1)) - 1);
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1 << (DATA_W - 1));

	typedef struct packed {
		logic [2:0][NUM_W-1:0] rem;
		logic [2:0][QUO_W-1:0] quo;
		logic [2:0]            neg;
		logic [DEN_W-1:0]      den;
		logic                  zero;
	} div_t;
endpackage
`default_nettype wire

[sv/qvr_if.sv]
// Channel interfaces for the rotation block: quaternion plus vector in,
// rotated vector and flags out. Valid/ready handshake. No dependencies.
`default_nettype none
interface qvr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] vec_x;
	logic signed [15:0] vec_y;
	logic signed [15:0] vec_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		output ready);
endinterface

interface qvr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic               zero_quat;
	logic               saturated;

	modport source (output valid, out_x, out_y, out_z, zero_quat, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, zero_quat, saturated, output ready);
endinterface
`default_nettype wire

[sv/qvr_front.sv]
// Front end: part products, rotation matrix and norm, R*v, row sums and
// divider operands over five register stages. Uses qvr_pkg.
`default_nettype none
module qvr_front
	import qvr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic [FRONT_STG-1:0]    en,
	input  wire logic signed [DATA_W-1:0] quat_w,
	input  wire logic signed [DATA_W-1:0] quat_x,
	input  wire logic signed [DATA_W-1:0] quat_y,
	input  wire logic signed [DATA_W-1:0] quat_z,
	input  wire logic signed [DATA_W-1:0] vec_x,
	input  wire logic signed [DATA_W-1:0] vec_y,
	input  wire logic signed [DATA_W-1:0] vec_z,
	output div_t                          dout
);
	// stage 1: the ten part products
	logic signed [SQ_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [2:0][DATA_W-1:0] v_s1, v_s2;
	// stage 2: matrix and norm
	logic signed [2:0][2:0][MAT_W-1:0] m_s2;
	logic [NORM_W-1:0] n_s2, n_s3, n_s4;
	// stage 3: matrix times vector
	logic signed [2:0][2:0][PROD_W-1:0] p_s3;
	// stage 4: row sums
	logic signed [2:0][SUM_W-1:0] r_s4;

	logic signed [MAT_W-1:0] ww_e, xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, wx_e, wy_e, wz_e;
	logic [2:0][NUM_W-1:0]   num;
	logic [2:0]              neg;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ww_s1 <= quat_w * quat_w;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xy_s1 <= quat_x * quat_y;
			xz_s1 <= quat_x * quat_z;
			yz_s1 <= quat_y * quat_z;
			wx_s1 <= quat_w * quat_x;
			wy_s1 <= quat_w * quat_y;
			wz_s1 <= quat_w * quat_z;
			v_s1  <= {vec_z, vec_y, vec_x};
		end
	end

	always_comb begin
		ww_e = MAT_W'(ww_s1);
		xx_e = MAT_W'(xx_s1);
		yy_e = MAT_W'(yy_s1);
		zz_e = MAT_W'(zz_s1);
		xy_e = MAT_W'(xy_s1);
		xz_e = MAT_W'(xz_s1);
		yz_e = MAT_W'(yz_s1);
		wx_e = MAT_W'(wx_s1);
		wy_e = MAT_W'(wy_s1);
		wz_e = MAT_W'(wz_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			m_s2[0][0] <= ww_e + xx_e - yy_e - zz_e;
			m_s2[0][1] <= (xy_e - wz_e) <<< 1;
			m_s2[0][2] <= (xz_e + wy_e) <<< 1;
			m_s2[1][0] <= (xy_e + wz_e) <<< 1;
			m_s2[1][1] <= ww_e - xx_e + yy_e - zz_e;
			m_s2[1][2] <= (yz_e - wx_e) <<< 1;
			m_s2[2][0] <= (xz_e - wy_e) <<< 1;
			m_s2[2][1] <= (yz_e + wx_e) <<< 1;
			m_s2[2][2] <= ww_e - xx_e - yy_e + zz_e;
			n_s2       <= NORM_W'(ww_e + xx_e + yy_e + zz_e);
			v_s2       <= v_s1;
		end
	end

	// element selects of a packed array are unsigned, so re-sign them
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s3[i][j] <= PROD_W'($signed(m_s2[i][j])) * PROD_W'($signed(v_s2[j]));
				end
			end
			n_s3 <= n_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				r_s4[i] <= SUM_W'($signed(p_s3[i][0])) + SUM_W'($signed(p_s3[i][1]))
					+ SUM_W'($signed(p_s3[i][2]));
			end
			n_s4 <= n_s3;
		end
	end

	// rounding to nearest: floor((2|r| + n) / 2n)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i] = r_s4[i][SUM_W-1];
			num[i] = neg[i] ? (NUM_W'(-$signed(r_s4[i])) << 1)
				: (NUM_W'($signed(r_s4[i])) << 1);
			num[i] = num[i] + NUM_W'(n_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dout.rem  <= num;
			dout.quo  <= '0;
			dout.neg  <= neg;
			dout.den  <= {n_s4, 1'b0};
			dout.zero <= (n_s4 == '0);
		end
	end
endmodule
`default_nettype wire

[sv/qvr_div_stage.sv]
// One restoring-division step for all three components: resolves one
// quotient bit per register stage. Uses qvr_pkg.
`default_nettype none
module qvr_div_stage
	import qvr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [IDX_W-1:0] bit_idx,
	input  div_t                  din,
	output div_t                  dout
);
	div_t             nxt;
	logic [NUM_W-1:0] shd;

	always_comb begin
		nxt = din;
		shd = NUM_W'(din.den) << bit_idx;
		for (int c = 0; c < 3; c++) begin
			if (din.rem[c] >= shd) begin
				nxt.rem[c] = din.rem[c] - shd;
				nxt.quo[c] = din.quo[c] | (QUO_W'(1) << bit_idx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule
`default_nettype wire

[sv/quaternion_vector_rotation_top.sv]
// Pipeline: an accepted transaction passes through 5 arithmetic stages, 17
// one-bit divider stages and an output register before its result appears.
// Throughput: one transaction per cycle unless the output stalls; a stage
// advances when empty or its successor advances; bubbles close up behind a stall.
// Reset: arst_n clears the stage valid bits only; no other state.
`default_nettype none
module quaternion_vector_rotation_top
	import qvr_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	qvr_in_if.sink    sample,
	qvr_out_if.source rotated
);
	logic [NSTG-1:0] vld_q, adv;
	div_t            stg [0:QUO_W];

	logic [2:0][DATA_W-1:0] res;
	logic [2:0]             clip;
	logic [QUO_W-1:0]       lim;

	logic signed [2:0][DATA_W-1:0] out_s23;
	logic                          zero_s23, sat_s23;

	assign adv[NSTG-1] = !vld_q[NSTG-1] || rotated.ready;
	for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end

	assign sample.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (adv & {vld_q[NSTG-2:0], sample.valid}) | (~adv & vld_q);
		end
	end

	qvr_front u_front (
		.clk    (clk),
		.en     (adv[FRONT_STG-1:0]),
		.quat_w (sample.quat_w),
		.quat_x (sample.quat_x),
		.quat_y (sample.quat_y),
		.quat_z (sample.quat_z),
		.vec_x  (sample.vec_x),
		.vec_y  (sample.vec_y),
		.vec_z  (sample.vec_z),
		.dout   (stg[0])
	);

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		qvr_div_stage u_div (
			.clk     (clk),
			.en      (adv[FRONT_STG+g]),
			.bit_idx (IDX_W'(QUO_W - 1 - g)),
			.din     (stg[g]),
			.dout    (stg[g+1])
		);
	end

	// clamp and restore sign
	always_comb begin
		lim = POS_LIM;
		for (int c = 0; c < 3; c++) begin
			lim     = stg[QUO_W].neg[c] ? NEG_LIM : POS_LIM;
			clip[c] = stg[QUO_W].quo[c] > lim;
			res[c]  = clip[c] ? DATA_W'(lim) : DATA_W'(stg[QUO_W].quo[c]);
			if (stg[QUO_W].neg[c]) begin
				res[c] = DATA_W'(-res[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			if (stg[QUO_W].zero) begin
				out_s23 <= '0;
				sat_s23 <= 1'b0;
			end else begin
				out_s23 <= res;
				sat_s23 <= |clip;
			end
			zero_s23 <= stg[QUO_W].zero;
		end
	end

	assign rotated.valid     = vld_q[NSTG-1];
	assign rotated.out_x     = out_s23[0];
	assign rotated.out_y     = out_s23[1];
	assign rotated.out_z     = out_s23[2];
	assign rotated.zero_quat = zero_s23;
	assign rotated.saturated = sat_s23;
endmodule
`default_nettype wire

[sv/qvr_checker.sv]
// Port-level checks for the rotation block, attached to the top level by
// the bind at the end of this file. Uses no package.
`default_nettype none
module qvr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] out_x,
	input wire logic [15:0] out_y,
	input wire logic [15:0] out_z,
	input wire logic        zero_quat,
	input wire logic        saturated
);
	// a result held back keeps its transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(zero_quat) && $stable(saturated))
		else $error("stalled result changed");

	// input is refused only when the pipe is full behind a stalled output
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused with output free");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_quat |-> out_x == 16'h0 && out_y == 16'h0 && out_z == 16'h0
			&& !saturated)
		else $error("zero quaternion gave nonzero result");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> out_x == 16'h7fff || out_x == 16'h8000
			|| out_y == 16'h7fff || out_y == 16'h8000
			|| out_z == 16'h7fff || out_z == 16'h8000)
		else $error("saturation flagged without a clamped component");
endmodule

bind quaternion_vector_rotation_top qvr_checker u_qvr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (rotated.valid),
	.out_ready (rotated.ready),
	.out_x     (rotated.out_x),
	.out_y     (rotated.out_y),
	.out_z     (rotated.out_z),
	.zero_quat (rotated.zero_quat),
	.saturated (rotated.saturated)
);
`default_nettype wire
